>>> rtl/core/lsdh_pkg.sv
// shared types and constants for the log slot duplicate and hole checker
package lsdh_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH,
        ST_RD,
        ST_WR,
        ST_CKEY,
        ST_CRD,
        ST_CCNT,
        ST_DONE
    } t_state;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_CHECK  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    localparam logic [9:0]  GAP_RESET  = 10'd50;
    localparam logic [14:0] HOLE_MAX   = 15'h7fff;
    localparam logic [4:0]  UNSEEN_MAX = 5'h1f;
    localparam logic [31:0] DUP_MAX    = 32'hffff_ffff;

endpackage

>>> rtl/core/lsdh_slot_mem.sv
// single port occupancy bit memory with registered read
module lsdh_slot_mem #(
    parameter longint DEPTH = 16384,
    parameter int     AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lsdh_key_table.sv
// raw key store with one shared equality compare
module lsdh_key_table #(
    parameter int KEYS = 16,
    parameter int KW   = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [KW-1:0] i_widx,
    input  logic [KW-1:0] i_ridx,
    input  logic [63:0]   i_key,
    output logic          o_match
);

    logic [63:0] r_keys [KEYS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_widx] <= i_key;
        end
    end

    assign o_match = (r_keys[i_ridx] == i_key);

endmodule

>>> rtl/core/log_slot_duplicate_hole_checker_unit.sv
// top level: sequencer for key lookup, slot update and hole scan
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------
//  input    | i_valid  | o_stall  | i_opcode, i_raw_key, i_log_number
//  output   | o_valid  | i_stall  | o_status, o_dense_key, o_duplicate_count,
//           |          |          | o_hole_count, o_malignant_count,
//           |          |          | o_unseen_key_count
//  config   | i_cfg_we | -        | i_cfg_data
//
// insert: accept, key lookup over the used keys, slot memory read and write, result
// check: accept, a step per key, an end step, a read and a count per scanned slot, result
// after reset every slot memory bit is cleared, input stalled
// one transaction at a time; result held in the output register until taken
module log_slot_duplicate_hole_checker_unit #(
    parameter int KEYS = 16,
    parameter int LOGS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_raw_key,
    input  logic [19:0] i_log_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_dense_key,
    output logic [31:0] o_duplicate_count,
    output logic [14:0] o_hole_count,
    output logic [14:0] o_malignant_count,
    output logic [4:0]  o_unseen_key_count,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data
);

    localparam longint SLOTS = longint'(KEYS) * longint'(LOGS);
    localparam int     KW    = $clog2(KEYS);
    localparam int     CW    = $clog2(KEYS + 1);
    localparam int     LW    = $clog2(LOGS);
    localparam int     AW    = $clog2(SLOTS);

    lsdh_pkg::t_state r_state, n_state;

    logic [9:0]    r_gap;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_k;
    logic [KW-1:0] r_kidx;
    logic [LW-1:0] r_l;
    logic [LW-1:0] r_h;
    logic [19:0]   r_log;
    logic [63:0]   r_key;
    logic [AW-1:0] r_clr;
    logic [LW-1:0] r_high [KEYS];
    logic [KEYS-1:0] r_seen;
    logic [31:0]   r_dup;
    logic [1:0]    r_status;
    logic [3:0]    r_dense_key;
    logic [14:0]   r_holes;
    logic [14:0]   r_malig;
    logic [4:0]    r_unseen;

    logic          mem_we;
    logic          mem_wdata;
    logic [AW-1:0] mem_addr;
    logic          mem_rdata;
    logic          key_we;
    logic          key_match;
    logic          srch_end;
    logic          srch_hit;
    logic          tbl_full;
    logic          log_bad;
    logic          clr_last;
    logic          gap_big;

    assign srch_end = (r_k == r_used);
    assign srch_hit = !srch_end && key_match;
    assign tbl_full = (r_used >= CW'(KEYS));
    assign log_bad  = ({1'b0, r_log} >= 21'(LOGS));
    assign clr_last = (r_clr == AW'(SLOTS - 1));
    assign gap_big  = (21'(r_h - r_l) > 21'(r_gap));

    lsdh_key_table #(.KEYS(KEYS), .KW(KW)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_widx  (r_used[KW-1:0]),
        .i_ridx  (r_k[KW-1:0]),
        .i_key   (r_key),
        .o_match (key_match)
    );

    lsdh_slot_mem #(.DEPTH(SLOTS), .AW(AW)) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsdh_pkg::ST_CLEAR: if (clr_last) n_state = lsdh_pkg::ST_IDLE;
            lsdh_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_opcode == lsdh_pkg::OP_CHECK) ? lsdh_pkg::ST_CKEY
                                                               : lsdh_pkg::ST_SRCH;
                end
            end
            lsdh_pkg::ST_SRCH: begin
                if (srch_hit) begin
                    n_state = lsdh_pkg::ST_RD;
                end else if (srch_end) begin
                    n_state = tbl_full ? lsdh_pkg::ST_DONE : lsdh_pkg::ST_RD;
                end
            end
            lsdh_pkg::ST_RD:   n_state = log_bad ? lsdh_pkg::ST_DONE : lsdh_pkg::ST_WR;
            lsdh_pkg::ST_WR:   n_state = lsdh_pkg::ST_DONE;
            lsdh_pkg::ST_CKEY: begin
                if (srch_end) begin
                    n_state = lsdh_pkg::ST_DONE;
                end else if (r_seen[r_k[KW-1:0]] && (r_high[r_k[KW-1:0]] != '0)) begin
                    n_state = lsdh_pkg::ST_CRD;
                end
            end
            lsdh_pkg::ST_CRD:  n_state = lsdh_pkg::ST_CCNT;
            lsdh_pkg::ST_CCNT: n_state = (r_l == r_h) ? lsdh_pkg::ST_CKEY : lsdh_pkg::ST_CRD;
            lsdh_pkg::ST_DONE: if (!i_stall) n_state = lsdh_pkg::ST_IDLE;
            default:           n_state = lsdh_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_stall   = (r_state != lsdh_pkg::ST_IDLE);
        o_valid   = (r_state == lsdh_pkg::ST_DONE);
        key_we    = (r_state == lsdh_pkg::ST_SRCH) && srch_end && !tbl_full;
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = AW'(r_kidx) * AW'(LOGS) + AW'(r_l);
        if (r_state == lsdh_pkg::ST_CLEAR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr;
        end else if (r_state == lsdh_pkg::ST_WR && !mem_rdata) begin
            mem_we    = 1'b1;
            mem_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsdh_pkg::ST_CLEAR;
            r_gap   <= lsdh_pkg::GAP_RESET;
            r_used  <= '0;
            r_clr   <= '0;
            r_seen  <= '0;
            r_dup   <= '0;
            for (int i = 0; i < KEYS; i++) begin
                r_high[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            unique case (r_state)
                lsdh_pkg::ST_CLEAR: r_clr <= r_clr + AW'(1);
                lsdh_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_key       <= i_raw_key;
                        r_log       <= i_log_number;
                        r_l         <= i_log_number[LW-1:0];
                        r_k         <= '0;
                        r_kidx      <= '0;
                        r_status    <= lsdh_pkg::STAT_OK;
                        r_dense_key <= '0;
                        r_holes     <= '0;
                        r_malig     <= '0;
                        r_unseen    <= '0;
                    end
                end
                lsdh_pkg::ST_SRCH: begin
                    if (srch_hit) begin
                        r_kidx      <= r_k[KW-1:0];
                        r_dense_key <= 4'(r_k[KW-1:0]);
                    end else if (srch_end) begin
                        if (tbl_full) begin
                            r_status <= lsdh_pkg::STAT_FULL;
                        end else begin
                            r_kidx      <= r_used[KW-1:0];
                            r_dense_key <= 4'(r_used[KW-1:0]);
                            r_used      <= r_used + CW'(1);
                        end
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                lsdh_pkg::ST_RD: if (log_bad) r_status <= lsdh_pkg::STAT_RANGE;
                lsdh_pkg::ST_WR: begin
                    if (mem_rdata) begin
                        r_status <= lsdh_pkg::STAT_DUP;
                        if (r_dup != lsdh_pkg::DUP_MAX) r_dup <= r_dup + 32'd1;
                    end else begin
                        r_seen[r_kidx] <= 1'b1;
                        if (r_l > r_high[r_kidx]) r_high[r_kidx] <= r_l;
                    end
                end
                lsdh_pkg::ST_CKEY: begin
                    if (!srch_end) begin
                        r_kidx <= r_k[KW-1:0];
                        r_h    <= r_high[r_k[KW-1:0]];
                        r_l    <= LW'(1);
                        if (!r_seen[r_k[KW-1:0]]) begin
                            if (r_unseen != lsdh_pkg::UNSEEN_MAX) r_unseen <= r_unseen + 5'd1;
                            r_k <= r_k + CW'(1);
                        end else if (r_high[r_k[KW-1:0]] == '0) begin
                            r_k <= r_k + CW'(1);
                        end
                    end
                end
                lsdh_pkg::ST_CRD: ;
                lsdh_pkg::ST_CCNT: begin
                    if (!mem_rdata) begin
                        if (r_holes != lsdh_pkg::HOLE_MAX) r_holes <= r_holes + 15'd1;
                        if (gap_big && r_malig != lsdh_pkg::HOLE_MAX) begin
                            r_malig <= r_malig + 15'd1;
                        end
                    end
                    if (r_l == r_h) begin
                        r_k <= r_k + CW'(1);
                    end else begin
                        r_l <= r_l + LW'(1);
                    end
                end
                lsdh_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    assign o_status           = r_status;
    assign o_dense_key        = r_dense_key;
    assign o_duplicate_count  = r_dup;
    assign o_hole_count       = r_holes;
    assign o_malignant_count  = r_malig;
    assign o_unseen_key_count = r_unseen;

endmodule

>>> tb/lsdh_result_checker.sv
// checker that mirrors the hole checker state and compares every result transaction
`timescale 1ns / 1ps

module lsdh_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_raw_key,
    input  logic [19:0] i_log_number,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_status,
    input  logic [3:0]  o_dense_key,
    input  logic [31:0] o_duplicate_count,
    input  logic [14:0] o_hole_count,
    input  logic [14:0] o_malignant_count,
    input  logic [4:0]  o_unseen_key_count,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int NKEYS = 16;
    localparam int NLOGS = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  dense_key;
        logic [31:0] dup_count;
        logic [14:0] holes;
        logic [14:0] malignant;
        logic [4:0]  unseen;
    } t_report;

    logic [9:0]  gap_reg;
    logic [63:0] key_store [NKEYS];
    int          keys_alloc;
    bit          slot_map [NKEYS][NLOGS];
    logic [9:0]  top_log [NKEYS];
    bit          key_valid [NKEYS];
    logic [31:0] dup_total;
    t_report     report_q [$];

    function automatic t_report predict_report(logic op, logic [63:0] key, logic [19:0] lnum);
        t_report r;
        bit found;
        int k;
        r = '0;
        found = 0;
        if (op == lsdh_pkg::OP_INSERT) begin
            for (k = 0; k < keys_alloc; k++) begin
                if (!found && key_store[k] == key) begin
                    found = 1;
                    r.dense_key = k[3:0];
                end
            end
            if (!found) begin
                if (keys_alloc >= NKEYS) begin
                    r.status = lsdh_pkg::STAT_FULL;
                end else begin
                    r.dense_key = keys_alloc[3:0];
                    key_store[keys_alloc] = key;
                    keys_alloc++;
                    found = 1;
                end
            end
            if (found) begin
                if (lnum >= NLOGS) begin
                    r.status = lsdh_pkg::STAT_RANGE;
                end else if (slot_map[r.dense_key][lnum]) begin
                    r.status = lsdh_pkg::STAT_DUP;
                    if (dup_total != lsdh_pkg::DUP_MAX) dup_total++;
                end else begin
                    slot_map[r.dense_key][lnum] = 1;
                    key_valid[r.dense_key] = 1;
                    if (lnum[9:0] > top_log[r.dense_key]) top_log[r.dense_key] = lnum[9:0];
                end
            end
        end else begin
            for (k = 0; k < keys_alloc; k++) begin
                if (!key_valid[k]) begin
                    if (r.unseen != lsdh_pkg::UNSEEN_MAX) r.unseen++;
                end else begin
                    for (int l = 1; l <= top_log[k]; l++) begin
                        if (!slot_map[k][l]) begin
                            if (r.holes != lsdh_pkg::HOLE_MAX) r.holes++;
                            if (int'(top_log[k]) - l > int'(gap_reg) &&
                                r.malignant != lsdh_pkg::HOLE_MAX)
                                r.malignant++;
                        end
                    end
                end
            end
        end
        r.dup_count = dup_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (!i_rst_n) begin
            gap_reg = lsdh_pkg::GAP_RESET;
            keys_alloc = 0;
            dup_total = '0;
            for (int k = 0; k < NKEYS; k++) begin
                top_log[k] = '0;
                key_valid[k] = 0;
                key_store[k] = '0;
                for (int l = 0; l < NLOGS; l++) slot_map[k][l] = 0;
            end
            report_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) gap_reg = i_cfg_data;
            if (i_valid && !o_stall)
                report_q.push_back(predict_report(i_opcode, i_raw_key, i_log_number));
            if (o_valid && !i_stall) begin
                got = '{o_status, o_dense_key, o_duplicate_count, o_hole_count,
                        o_malignant_count, o_unseen_key_count};
                if (report_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result transaction: %p", got);
                end else begin
                    want = report_q.pop_front();
                    if (want.status != got.status || want.dense_key != got.dense_key ||
                        want.dup_count != got.dup_count || want.holes != got.holes ||
                        want.malignant != got.malignant || want.unseen != got.unseen) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
        o_pending = report_q.size();
    end

endmodule

>>> tb/log_slot_duplicate_hole_checker_unit_test.sv
// stimulus and verdict for the log slot duplicate and hole checker
`timescale 1ns / 1ps

module log_slot_duplicate_hole_checker_unit_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic [63:0] i_raw_key;
    logic [19:0] i_log_number;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [3:0]  o_dense_key;
    logic [31:0] o_duplicate_count;
    logic [14:0] o_hole_count;
    logic [14:0] o_malignant_count;
    logic [4:0]  o_unseen_key_count;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_data;
    int          fail_count;
    int          pending;

    bit          idle_on;
    int          sent_count;
    int          insert_count;
    int          check_count;
    logic [63:0] key_pool [16];

    log_slot_duplicate_hole_checker_unit dut (.*);

    lsdh_result_checker checker_inst (
        .o_errors(fail_count),
        .o_pending(pending),
        .*
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = lsdh_pkg::OP_INSERT;
        i_raw_key = '0;
        i_log_number = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        bit held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= 600) begin
                held = 1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            i_stall <= idle_on && ($urandom_range(99) < 21);
        end
    end

    task automatic offer_entry(logic op, logic [63:0] key, logic [19:0] lnum);
        while (idle_on && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_raw_key <= key;
        i_log_number <= lnum;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
        if (op == lsdh_pkg::OP_CHECK) check_count++;
        else insert_count++;
    endtask

    task automatic drain_and_write(logic [9:0] gap);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= gap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_entry();
        int pick;
        logic [63:0] key;
        logic [19:0] lnum;
        pick = $urandom_range(15);
        key = key_pool[pick];
        if ($urandom_range(99) < 8) key = {$urandom, $urandom};
        case ($urandom_range(99)) inside
            [0:84]:  lnum = 20'($urandom_range(40));
            [85:93]: lnum = (pick < 3) ? 20'($urandom_range(1023)) : 20'($urandom_range(80));
            default: lnum = 20'($urandom_range(20'hfffff, 1024));
        endcase
        if ($urandom_range(99) < 3)
            offer_entry(lsdh_pkg::OP_CHECK, {$urandom, $urandom}, 20'($urandom));
        else offer_entry(lsdh_pkg::OP_INSERT, key, lnum);
    endtask

    initial begin
        logic [9:0] gaps [4];
        idle_on = 1;
        sent_count = 0;
        insert_count = 0;
        check_count = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 16; k++) key_pool[k] = {$urandom, $urandom};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the reset threshold
        offer_entry(lsdh_pkg::OP_CHECK, '0, '0);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[1], 20'd0);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[1], 20'd0);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[0], 20'd1023);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[0], 20'd1024);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[0], 20'd5);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[0], 20'd1023);
        offer_entry(lsdh_pkg::OP_INSERT, 64'h5a5a_a5a5_0f0f_f0f0, 20'hfffff);
        offer_entry(lsdh_pkg::OP_INSERT, key_pool[1], 20'd3);
        offer_entry(lsdh_pkg::OP_CHECK, '1, '1);
        for (int k = 2; k < 16; k++) offer_entry(lsdh_pkg::OP_INSERT, key_pool[k], 20'(k));
        offer_entry(lsdh_pkg::OP_INSERT, 64'h1234_5678_9abc_def0, 20'd1);
        offer_entry(lsdh_pkg::OP_CHECK, '0, '0);

        gaps[0] = 10'd0;
        gaps[1] = 10'd1023;
        gaps[2] = 10'($urandom_range(1023));
        gaps[3] = 10'($urandom_range(60));
        for (int p = 0; p < 4; p++) begin
            drain_and_write(gaps[p]);
            idle_on = (p != 1);
            for (int n = 0; n < 430; n++) random_entry();
            offer_entry(lsdh_pkg::OP_CHECK, '0, '0);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d inserts and %0d checks over 5 threshold settings",
                 insert_count, check_count);
        $display("with random stalls, an idle-free stretch and a long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
